[rtl/dfr_pkg.sv]
// Shared types and codes for the delimited frame receiver.
package dfr_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DELIM   = 1'b1;

    localparam logic [7:0] START_DELIM_RST = 8'd2;
    localparam logic [7:0] END_DELIM_RST   = 8'd3;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_WIPE = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        ST_STARTED    = 4'd0,
        ST_APPENDED   = 4'd1,
        ST_IGNORED    = 4'd2,
        ST_QUEUED     = 4'd3,
        ST_QUEUE_FULL = 4'd4,
        ST_BUF_FULL   = 4'd5,
        ST_MSG_BYTE   = 4'd6,
        ST_EMPTY      = 4'd7,
        ST_WIPED      = 4'd8
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic [5:0] byte_index;
        logic [6:0] message_length;
        logic       last;
        logic [3:0] messages_waiting;
        logic       frame_open;
    } t_result;

endpackage

[rtl/dfr_in_if.sv]
// Input channel: one command with its received byte.
interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

[rtl/dfr_out_if.sv]
// Output channel: one result item per transfer.
interface dfr_out_if;
    logic             valid;
    logic             ready;
    dfr_pkg::t_status status;
    logic [7:0]       out_byte;
    logic [5:0]       byte_index;
    logic [6:0]       message_length;
    logic             last;
    logic [3:0]       messages_waiting;
    logic             frame_open;

    modport source (output valid, output status, output out_byte, output byte_index,
                    output message_length, output last, output messages_waiting,
                    output frame_open, input ready);
    modport sink   (input valid, input status, input out_byte, input byte_index,
                    input message_length, input last, input messages_waiting,
                    input frame_open, output ready);
endinterface

[rtl/delimited_frame_receiver_fifo.sv]
// Delimited frame receiver: push, pop and wipe commands over a memory-based message queue.
// Push, wipe, an empty pop and the unused mode each give one result; the next command is
// taken in the cycle after, provided that result leaves the output register in that same
// cycle. A pop of a waiting message gives MSG_BYTES results, one per cycle while the output
// is not stalled, after a first read of the message memory, and no command is taken
// until its last result; the single read port of the byte memory sets that rate.
// Bytes of the open frame are written straight into a spare slot of a ring of QUEUE_DEPTH + 1
// message slots, so an end delimiter queues the frame by writing its length and advancing
// the tail, with no copy. There is no clearing pass after reset.
module delimited_frame_receiver_fifo #(
    parameter int MSG_BYTES   = 64,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dfr_in_if.sink                           i_in,
    dfr_out_if.source                        o_out
);

    localparam int IW        = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int LW        = $clog2(MSG_BYTES + 1);
    localparam int SW        = $clog2(QUEUE_DEPTH + 1);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int AW        = SW + IW;
    localparam int MEM_DEPTH = (QUEUE_DEPTH + 1) << IW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    logic [7:0]        byte_mem [MEM_DEPTH];
    logic [LW-1:0]     len_mem  [QUEUE_DEPTH + 1];

    logic [7:0]        r_start_delim;
    logic [7:0]        r_end_delim;
    t_state            r_state,   n_state;
    logic [LW-1:0]     r_flen,    n_flen;
    logic              r_factive, n_factive;
    logic [SW-1:0]     r_head,    n_head;
    logic [SW-1:0]     r_tail,    n_tail;
    logic [CW-1:0]     r_count,   n_count;
    logic [SW-1:0]     r_pslot,   n_pslot;
    logic [IW-1:0]     r_idx,     n_idx;
    logic              r_out_valid, n_out_valid;
    dfr_pkg::t_result  r_out,     n_out;
    logic [7:0]        r_rd_byte;
    logic [LW-1:0]     r_rd_len;

    logic              w_out_free;
    logic              w_in_ready;
    logic              w_in_fire;
    logic              w_bwe;
    logic [AW-1:0]     w_baddr;
    logic [7:0]        w_bdata;
    logic              w_lwe;
    logic [LW-1:0]     w_ldata;
    logic [SW-1:0]     w_tail_inc;
    logic [SW-1:0]     w_head_inc;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in.valid && w_in_ready;
    assign w_tail_inc = (r_tail == SW'(QUEUE_DEPTH)) ? '0 : r_tail + 1'b1;
    assign w_head_inc = (r_head == SW'(QUEUE_DEPTH)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_flen      = r_flen;
        n_factive   = r_factive;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pslot     = r_pslot;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        w_bwe       = 1'b0;
        w_baddr     = {r_tail, r_flen[IW-1:0]};
        w_bdata     = i_in.in_byte;
        w_lwe       = 1'b0;
        w_ldata     = r_flen;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = dfr_pkg::ST_IGNORED;
                    n_out.out_byte       = '0;
                    n_out.byte_index     = '0;
                    n_out.message_length = 7'(r_flen);
                    n_out.last           = 1'b1;
                    unique case (i_in.mode)
                        dfr_pkg::MODE_PUSH: begin
                            priority if (i_in.in_byte == r_start_delim) begin
                                n_flen               = '0;
                                n_factive            = 1'b1;
                                n_out.status         = dfr_pkg::ST_STARTED;
                                n_out.message_length = '0;
                            end else if (!r_factive) begin
                                n_out.status = dfr_pkg::ST_IGNORED;
                            end else if (i_in.in_byte == r_end_delim) begin
                                n_flen    = '0;
                                n_factive = 1'b0;
                                if (r_count == CW'(QUEUE_DEPTH)) begin
                                    n_out.status = dfr_pkg::ST_QUEUE_FULL;
                                end else begin
                                    // The frame already sits in the tail slot.
                                    w_lwe        = 1'b1;
                                    n_tail       = w_tail_inc;
                                    n_count      = r_count + 1'b1;
                                    n_out.status = dfr_pkg::ST_QUEUED;
                                end
                            end else if (r_flen == LW'(MSG_BYTES)) begin
                                n_out.status = dfr_pkg::ST_BUF_FULL;
                            end else begin
                                w_bwe                = 1'b1;
                                n_flen               = r_flen + 1'b1;
                                n_out.status         = dfr_pkg::ST_APPENDED;
                                n_out.message_length = 7'(r_flen + 1'b1);
                            end
                        end
                        dfr_pkg::MODE_POP: begin
                            if (r_count == '0) begin
                                n_out.status         = dfr_pkg::ST_EMPTY;
                                n_out.message_length = '0;
                            end else begin
                                n_out_valid = 1'b0;
                                n_pslot     = r_head;
                                n_idx       = '0;
                                n_head      = w_head_inc;
                                n_count     = r_count - 1'b1;
                                n_state     = S_POP;
                            end
                        end
                        dfr_pkg::MODE_WIPE: begin
                            n_flen               = '0;
                            n_head               = '0;
                            n_tail               = '0;
                            n_count              = '0;
                            n_out.status         = dfr_pkg::ST_WIPED;
                            n_out.message_length = '0;
                        end
                        default: begin
                            n_out.status = dfr_pkg::ST_IGNORED;
                        end
                    endcase
                    n_out.messages_waiting = 4'(n_count);
                    n_out.frame_open       = n_factive;
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out.status           = dfr_pkg::ST_MSG_BYTE;
                    // Bytes past the message length read as zero.
                    n_out.out_byte         = (LW'(r_idx) < r_rd_len) ? r_rd_byte : 8'd0;
                    n_out.byte_index       = 6'(r_idx);
                    n_out.message_length   = 7'(r_rd_len);
                    n_out.last             = (r_idx == IW'(MSG_BYTES - 1));
                    n_out.messages_waiting = 4'(r_count);
                    n_out.frame_open       = r_factive;
                    if (r_idx == IW'(MSG_BYTES - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= dfr_pkg::START_DELIM_RST;
            r_end_delim   <= dfr_pkg::END_DELIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dfr_pkg::CFG_START_DELIM: r_start_delim <= i_cfg_data;
                dfr_pkg::CFG_END_DELIM:   r_end_delim   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flen      <= '0;
            r_factive   <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flen      <= n_flen;
            r_factive   <= n_factive;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pslot <= n_pslot;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    // The read address follows the next pop position, so the data lines up with r_idx.
    always_ff @(posedge i_clk) begin
        if (w_bwe) begin
            byte_mem[w_baddr] <= w_bdata;
        end
        r_rd_byte <= byte_mem[{n_pslot, n_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            len_mem[r_tail] <= w_ldata;
        end
        r_rd_len <= len_mem[n_pslot];
    end

    assign i_in.ready             = w_in_ready;
    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out.status;
    assign o_out.out_byte         = r_out.out_byte;
    assign o_out.byte_index       = r_out.byte_index;
    assign o_out.message_length   = r_out.message_length;
    assign o_out.last             = r_out.last;
    assign o_out.messages_waiting = r_out.messages_waiting;
    assign o_out.frame_open       = r_out.frame_open;

endmodule

[rtl/dfr_checker.sv]
// Port-level checks for the frame receiver, bound to its top level.
module dfr_checker #(
    parameter int MSG_BYTES = 64
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input dfr_pkg::t_status i_status,
    input logic [7:0]       i_out_byte,
    input logic [5:0]       i_byte_index,
    input logic [6:0]       i_message_length,
    input logic             i_last,
    input logic [3:0]       i_messages_waiting
);

    // A stalled result holds until its transfer.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_out_byte) && $stable(i_byte_index))
        else $error("result changed while stalled");

    // No command is taken while a message is still streaming out.
    a_pop_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == dfr_pkg::ST_MSG_BYTE) && !i_last |-> !i_in_ready)
        else $error("command taken in the middle of a message");

    a_single_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != dfr_pkg::ST_MSG_BYTE) |-> i_last)
        else $error("single result without last mark");

    a_msg_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == dfr_pkg::ST_MSG_BYTE) && i_last |->
            (i_byte_index == 6'(MSG_BYTES - 1)))
        else $error("message ended at the wrong byte index");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == dfr_pkg::ST_EMPTY) |->
            (i_messages_waiting == 4'd0) && (i_message_length == 7'd0))
        else $error("empty pop reported waiting messages or a length");

endmodule

bind delimited_frame_receiver_fifo dfr_checker #(
    .MSG_BYTES (MSG_BYTES)
) u_dfr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_status           (o_out.status),
    .i_out_byte         (o_out.out_byte),
    .i_byte_index       (o_out.byte_index),
    .i_message_length   (o_out.message_length),
    .i_last             (o_out.last),
    .i_messages_waiting (o_out.messages_waiting)
);
